@@ hdl/wstfe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package wstfe_pkg;

  // Frame header constants
  localparam logic [7:0]  HDR_FIN_TEXT = 8'h80 | 8'h01;
  localparam logic [7:0]  MASK_BIT     = 8'h80;
  localparam logic [7:0]  LEN16_CODE   = 8'd126;
  localparam logic [7:0]  LEN64_CODE   = 8'd127;
  localparam logic [31:0] LEN16_MAX    = 32'hFFFF;

  // Header byte position counter: up to 14 header bytes
  localparam int          IDX_W        = 4;

  // Default depth of the request queue between front and back
  localparam int          QUEUE_DEPTH  = 4;

  typedef enum logic [1:0] {
    JOB_START,
    JOB_DATA,
    JOB_MISUSE
  } job_kind_t;

  typedef enum logic [1:0] {
    FORM_SHORT,
    FORM_MID,
    FORM_LONG
  } len_form_t;

  // One classified request, handed from front to back
  typedef struct packed {
    job_kind_t   kind;
    len_form_t   form;
    logic [31:0] len;
    logic [31:0] key;
    logic [7:0]  dbyte;
    logic        fend;
  } job_t;

  // Key byte 0 sits in bits 31..24
  function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] sel);
    logic [7:0] b;
    case (sel)
      2'd0:    b = key[31:24];
      2'd1:    b = key[23:16];
      2'd2:    b = key[15:8];
      default: b = key[7:0];
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

@@ hdl/wstfe_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wstfe_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 acc,
  input  wire                 cmd,
  input  wire [31:0]          payload_length,
  input  wire [31:0]          mask_key,
  input  wire [7:0]           data_byte,
  output wstfe_pkg::job_t     job
);
  import wstfe_pkg::*;

  logic [31:0] bytes_left_r, bytes_left_nxt;
  logic [31:0] key_held_r, key_held_nxt;
  logic [1:0]  key_phase_r, key_phase_nxt;
  logic        frame_open_r, frame_open_nxt;
  logic [31:0] dec_left;

  assign dec_left = bytes_left_r - 32'd1;

  // Classify the request and advance the frame state
  always_comb begin
    bytes_left_nxt = bytes_left_r;
    key_held_nxt   = key_held_r;
    key_phase_nxt  = key_phase_r;
    frame_open_nxt = frame_open_r;

    job.kind  = JOB_MISUSE;
    job.form  = FORM_SHORT;
    job.len   = payload_length;
    job.key   = mask_key;
    job.dbyte = 8'h00;
    job.fend  = 1'b0;

    if (!cmd) begin
      job.kind = JOB_START;
      if (payload_length < 32'(LEN16_CODE)) begin
        job.form = FORM_SHORT;
      end else if (payload_length <= LEN16_MAX) begin
        job.form = FORM_MID;
      end else begin
        job.form = FORM_LONG;
      end
      job.fend = (payload_length == 32'd0);
      if (acc) begin
        bytes_left_nxt = payload_length;
        key_held_nxt   = mask_key;
        key_phase_nxt  = 2'd0;
        frame_open_nxt = (payload_length != 32'd0);
      end
    end else if (frame_open_r) begin
      job.kind  = JOB_DATA;
      job.dbyte = data_byte ^ key_byte(key_held_r, key_phase_r);
      job.fend  = (dec_left == 32'd0);
      if (acc) begin
        bytes_left_nxt = dec_left;
        key_phase_nxt  = key_phase_r + 2'd1;
        frame_open_nxt = (dec_left != 32'd0);
      end
    end
  end

  // Hold frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= '0;
      key_held_r   <= '0;
      key_phase_r  <= '0;
      frame_open_r <= 1'b0;
    end else begin
      bytes_left_r <= bytes_left_nxt;
      key_held_r   <= key_held_nxt;
      key_phase_r  <= key_phase_nxt;
      frame_open_r <= frame_open_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_open_matches_left: assert property (@(posedge clk) disable iff (!rst_n)
    frame_open_r == (bytes_left_r != 32'd0))
    else $error("frame open flag disagrees with remaining count");

  a_misuse_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && cmd && !frame_open_r) |=> ($stable(bytes_left_r) && $stable(key_phase_r)))
    else $error("stray payload byte changed frame state");
`endif

endmodule

`default_nettype wire

@@ hdl/wstfe_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wstfe_queue #(
  parameter int DEPTH = wstfe_pkg::QUEUE_DEPTH
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 wr_en,
  input  wire wstfe_pkg::job_t wr_job,
  input  wire                 rd_en,
  output wstfe_pkg::job_t     rd_job,
  output logic                q_full,
  output logic                q_empty
);
  import wstfe_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign q_full  = (count_r == CW'(DEPTH));
  assign q_empty = (count_r == '0);
  assign rd_job  = slot_r[rd_ptr_r];

  // Advance pointers with wrap and track the fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + CW'(1);
    end else if (!wr_en && rd_en) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store request payload
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= wr_job;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue fill count beyond depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !rd_en) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("queue fill count did not step on write");
`endif

endmodule

`default_nettype wire

@@ hdl/wstfe_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wstfe_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 q_empty,
  input  wire wstfe_pkg::job_t head,
  output logic                q_pop,
  output logic                empty,
  input  wire                 pop,
  output logic [7:0]          out_byte,
  output logic                out_run_last,
  output logic                out_frame_end,
  output logic                out_misuse
);
  import wstfe_pkg::*;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] last_idx, key_ofs;
  logic [1:0]       key_sel;
  logic [7:0]       byte_c;
  logic             last_c, fend_c, misuse_c;
  logic             load;
  logic             out_vld_r;
  logic [7:0]       out_byte_r;
  logic             out_run_last_r, out_frame_end_r, out_misuse_r;

  assign load    = !q_empty && (!out_vld_r || pop);
  assign key_sel = 2'(idx_r - key_ofs);

  // Build the byte at the current header position, the single payload byte, or a misuse result
  always_comb begin
    case (head.form)
      FORM_SHORT: begin
        last_idx = IDX_W'(5);
        key_ofs  = IDX_W'(2);
      end
      FORM_MID: begin
        last_idx = IDX_W'(7);
        key_ofs  = IDX_W'(4);
      end
      default: begin
        last_idx = IDX_W'(13);
        key_ofs  = IDX_W'(10);
      end
    endcase

    byte_c   = 8'h00;
    last_c   = 1'b1;
    fend_c   = 1'b0;
    misuse_c = 1'b0;

    case (head.kind)
      JOB_START: begin
        last_c = (idx_r == last_idx);
        fend_c = last_c && head.fend;
        if (idx_r == '0) begin
          byte_c = HDR_FIN_TEXT;
        end else if (idx_r >= key_ofs) begin
          byte_c = key_byte(head.key, key_sel);
        end else begin
          case (head.form)
            FORM_SHORT: byte_c = MASK_BIT | {1'b0, head.len[6:0]};
            FORM_MID: begin
              case (idx_r)
                IDX_W'(1): byte_c = MASK_BIT | LEN16_CODE;
                IDX_W'(2): byte_c = head.len[15:8];
                default:   byte_c = head.len[7:0];
              endcase
            end
            default: begin
              case (idx_r)
                IDX_W'(1): byte_c = MASK_BIT | LEN64_CODE;
                IDX_W'(6): byte_c = head.len[31:24];
                IDX_W'(7): byte_c = head.len[23:16];
                IDX_W'(8): byte_c = head.len[15:8];
                IDX_W'(9): byte_c = head.len[7:0];
                default:   byte_c = 8'h00;
              endcase
            end
          endcase
        end
      end
      JOB_DATA: begin
        byte_c = head.dbyte;
        fend_c = head.fend;
      end
      default: begin
        misuse_c = 1'b1;
      end
    endcase
  end

  // Drop the request from the queue on its last byte
  assign q_pop = load && last_c;

  always_comb begin
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = last_c ? '0 : idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (load) begin
        out_vld_r <= 1'b1;
      end else if (pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r      <= byte_c;
      out_run_last_r  <= last_c;
      out_frame_end_r <= fend_c;
      out_misuse_r    <= misuse_c;
    end
  end

  assign empty         = !out_vld_r;
  assign out_byte      = out_byte_r;
  assign out_run_last  = out_run_last_r;
  assign out_frame_end = out_frame_end_r;
  assign out_misuse    = out_misuse_r;

`ifndef NO_ASSERTIONS
  a_idx_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != '0) |-> !q_empty)
    else $error("header position advanced with no request queued");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!q_empty && head.kind == JOB_START) |-> (idx_r <= last_idx))
    else $error("header position beyond frame header");
`endif

endmodule

`default_nettype wire

@@ hdl/websocket_text_frame_encoder_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Handshake     | Ports
// ----------+---------------+---------------------------------------------------
// request   | push / full   | in_cmd, in_payload_length, in_mask_key, in_data_byte
// result    | empty / pop   | out_byte, out_run_last, out_frame_end, out_misuse
//
// A payload request yields one byte; a start request yields 6, 8 or 14 header
// bytes, one per cycle unless pop stalls, from the back end's header sequencer.
// The front end updates frame state on accept; a QUEUE_DEPTH-entry queue lets it
// keep taking requests while the back end spells out a header.
// An accepted request is written into the queue, then its bytes are registered at the outputs.
// Synchronous active-low reset empties the queue and closes any open frame.
// full rises only when the queue is full; pop stalls hold the output register.

module websocket_text_frame_encoder_top #(
  parameter int QUEUE_DEPTH = wstfe_pkg::QUEUE_DEPTH
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         push,
  output logic        full,
  input  wire         in_cmd,
  input  wire [31:0]  in_payload_length,
  input  wire [31:0]  in_mask_key,
  input  wire [7:0]   in_data_byte,
  output logic        empty,
  input  wire         pop,
  output logic [7:0]  out_byte,
  output logic        out_run_last,
  output logic        out_frame_end,
  output logic        out_misuse
);
  import wstfe_pkg::*;

  logic acc;
  logic q_full, q_empty, q_pop;
  job_t new_job, head_job;

  assign full = q_full;
  assign acc  = push && !q_full;

  wstfe_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .acc            (acc),
    .cmd            (in_cmd),
    .payload_length (in_payload_length),
    .mask_key       (in_mask_key),
    .data_byte      (in_data_byte),
    .job            (new_job)
  );

  wstfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (acc),
    .wr_job  (new_job),
    .rd_en   (q_pop),
    .rd_job  (head_job),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  wstfe_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .head          (head_job),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_frame_end (out_frame_end),
    .out_misuse    (out_misuse)
  );

`ifndef NO_ASSERTIONS
  a_misuse_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_misuse) |-> (out_run_last && !out_frame_end && out_byte == 8'h00))
    else $error("stray byte result carries frame data");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_frame_end) |-> out_run_last)
    else $error("frame end flagged mid request");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (full && !q_pop) |=> full)
    else $error("queue drained with no pop from back end");
`endif

endmodule

`default_nettype wire

@@ tb/tb_websocket_text_frame_encoder_top.sv @@
`timescale 1ns / 1ps

module tb_websocket_text_frame_encoder_top;
  import wstfe_pkg::*;

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_PAYLOAD = 1'b1;
  localparam int   HOLD_CYCLES = 300;
  localparam int   DRAIN_LIMIT = 20000;
  localparam int   RANDOM_ITEMS_PER_PHASE = 80;

  // One byte on the wire with its flags
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
    logic       misuse;
  } wire_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        in_cmd = 1'b0;
  logic [31:0] in_payload_length = '0;
  logic [31:0] in_mask_key = '0;
  logic [7:0]  in_data_byte = '0;
  logic        pop = 1'b0;
  logic        full;
  logic        empty;
  logic [7:0]  out_byte;
  logic        out_run_last;
  logic        out_frame_end;
  logic        out_misuse;

  // Predicted frame state
  logic [31:0] bytes_owed = '0;
  logic [31:0] frame_key = '0;
  logic [1:0]  key_pos = '0;
  logic        frame_is_open = 1'b0;

  wire_result_t wire_results_due[$];
  int mismatch_count = 0;
  int requests_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int stall_left = 0;

  websocket_text_frame_encoder_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_cmd            (in_cmd),
    .in_payload_length (in_payload_length),
    .in_mask_key       (in_mask_key),
    .in_data_byte      (in_data_byte),
    .empty             (empty),
    .pop               (pop),
    .out_byte          (out_byte),
    .out_run_last      (out_run_last),
    .out_frame_end     (out_frame_end),
    .out_misuse        (out_misuse)
  );

  always #10 clk = ~clk;

  // Work out the wire bytes one accepted request produces
  function automatic void frame_encode(input logic cmd, input logic [31:0] len,
                                       input logic [31:0] key, input logic [7:0] data);
    logic [7:0]   hdr[$];
    wire_result_t r;
    logic [7:0]   key_b;
    if (cmd == CMD_START) begin
      hdr.push_back(HDR_FIN_TEXT);
      if (len < 32'(LEN16_CODE)) begin
        hdr.push_back(MASK_BIT | len[7:0]);
      end else if (len <= LEN16_MAX) begin
        hdr.push_back(MASK_BIT | LEN16_CODE);
        hdr.push_back(len[15:8]);
        hdr.push_back(len[7:0]);
      end else begin
        hdr.push_back(MASK_BIT | LEN64_CODE);
        repeat (4) hdr.push_back(8'h00);
        hdr.push_back(len[31:24]);
        hdr.push_back(len[23:16]);
        hdr.push_back(len[15:8]);
        hdr.push_back(len[7:0]);
      end
      for (int k = 0; k < 4; k++) hdr.push_back(key[31 - 8 * k -: 8]);
      foreach (hdr[k]) begin
        r.out_byte  = hdr[k];
        r.run_last  = (k == hdr.size() - 1);
        r.frame_end = r.run_last && (len == 0);
        r.misuse    = 1'b0;
        wire_results_due.push_back(r);
      end
      // A new start abandons whatever frame was open
      bytes_owed    = len;
      frame_key     = key;
      key_pos       = '0;
      frame_is_open = (len != 0);
    end else if (!frame_is_open) begin
      r = '{out_byte: 8'h00, run_last: 1'b1, frame_end: 1'b0, misuse: 1'b1};
      wire_results_due.push_back(r);
    end else begin
      key_b = frame_key[31 - 8 * int'(key_pos) -: 8];
      bytes_owed = bytes_owed - 1;
      r.out_byte  = data ^ key_b;
      r.run_last  = 1'b1;
      r.frame_end = (bytes_owed == 0);
      r.misuse    = 1'b0;
      wire_results_due.push_back(r);
      key_pos = key_pos + 2'd1;
      if (bytes_owed == 0) frame_is_open = 1'b0;
    end
  endfunction

  // Offer one request, hold it until taken, then maybe idle
  task automatic send_request(input logic cmd, input logic [31:0] len,
                              input logic [31:0] key, input logic [7:0] data);
    push              <= 1'b1;
    in_cmd            <= cmd;
    in_payload_length <= len;
    in_mask_key       <= key;
    in_data_byte      <= data;
    do @(posedge clk); while (full);
    frame_encode(cmd, len, key, data);
    requests_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic send_start(input logic [31:0] len, input logic [31:0] key);
    send_request(CMD_START, len, key, 8'($urandom_range(255)));
  endtask

  task automatic send_payload(input logic [7:0] data);
    send_request(CMD_PAYLOAD, $urandom(), $urandom(), data);
  endtask

  // Compare one popped byte against the oldest prediction
  task automatic check_result();
    wire_result_t got;
    wire_result_t want;
    got = '{out_byte: out_byte, run_last: out_run_last, frame_end: out_frame_end,
            misuse: out_misuse};
    if (wire_results_due.size() == 0) begin
      mismatch_count++;
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
    end else begin
      want = wire_results_due.pop_front();
      if (got.out_byte !== want.out_byte) begin
        mismatch_count++;
        $display("%0t: out_byte expected %h actual %h", $time, want.out_byte, got.out_byte);
      end
      if (got.run_last !== want.run_last) begin
        mismatch_count++;
        $display("%0t: run_last expected %b actual %b", $time, want.run_last, got.run_last);
      end
      if (got.frame_end !== want.frame_end) begin
        mismatch_count++;
        $display("%0t: frame_end expected %b actual %b", $time, want.frame_end,
                 got.frame_end);
      end
      if (got.misuse !== want.misuse) begin
        mismatch_count++;
        $display("%0t: misuse expected %b actual %b", $time, want.misuse, got.misuse);
      end
    end
  endtask

  // Receive side: check popped bytes, then choose the next pop
  always @(posedge clk) begin
    if (rst_n && pop && !empty) check_result();
    if (holds_served != hold_requests) begin
      holds_served++;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Header forms, empty frame, misuse and abandoned frames
  task automatic test_directed_frames();
    send_payload(8'hFF);
    send_start(32'd0, 32'hFFFF_FFFF);
    send_payload(8'h00);
    send_start(32'd5, 32'h0102_0304);
    send_payload(8'h00);
    send_payload(8'hFF);
    send_payload(8'hA5);
    send_payload(8'h5A);
    send_payload(8'h3C);
    send_payload(8'h81);
    send_start(32'd125, 32'h0000_0000);
    send_payload(8'h7F);
    send_start(32'd126, 32'hDEAD_BEEF);
    send_payload(8'h12);
    send_payload(8'h34);
    send_start(32'h0000_FFFF, 32'h8000_0001);
    send_start(32'h0001_0000, 32'h7FFF_FFFE);
    send_start(32'hFFFF_FFFF, 32'hA5A5_A5A5);
    send_payload(8'h00);
    send_start(32'd1, 32'h1234_5678);
    send_payload(8'h80);
    send_payload(8'h01);
  endtask

  // Stall the receiver for a long stretch while requests keep coming
  task automatic test_output_backpressure();
    hold_requests++;
    send_start(32'd40, $urandom());
    repeat (40) send_payload(8'($urandom_range(255)));
  endtask

  // Mostly well-formed frames with random content, some cut short or overrun
  task automatic test_random_frames(input int send_pct, input int recv_pct);
    int target;
    int pick;
    int nbytes;
    logic [31:0] len;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    target = requests_sent + RANDOM_ITEMS_PER_PHASE;
    while (requests_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_payload(8'($urandom_range(255)));
      end else begin
        if (pick < 75) begin
          len = $urandom_range(16);
        end else if (pick < 88) begin
          case ($urandom_range(5))
            0: len = 32'd125;
            1: len = 32'd126;
            2: len = 32'd127;
            3: len = 32'h0000_FFFF;
            4: len = 32'h0001_0000;
            default: len = 32'hFFFF_FFFF;
          endcase
        end else begin
          len = $urandom();
        end
        send_start(len, $urandom());
        nbytes = (len > 16) ? $urandom_range(6) : int'(len);
        if ($urandom_range(9) == 0) nbytes = $urandom_range(nbytes);
        repeat (nbytes) send_payload(8'($urandom_range(255)));
        if ($urandom_range(7) == 0) send_payload(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    int drain_cycles;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 11;
    recv_idle_pct = 52;
    test_directed_frames();
    test_output_backpressure();
    test_random_frames(11, 52);
    test_random_frames(52, 11);
    test_random_frames(0, 0);
    push <= 1'b0;
    // Drain outstanding bytes, then allow for stragglers
    drain_cycles = 0;
    while (wire_results_due.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (8) @(posedge clk);
    if (wire_results_due.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d expected results never arrived, next expected %h",
               $time, wire_results_due.size(), wire_results_due[0]);
    end
    if (mismatch_count == 0) begin
      $display("websocket_text_frame_encoder_top verification clean");
    end else begin
      $display("websocket_text_frame_encoder_top verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("websocket_text_frame_encoder_top verification failed");
    $finish;
  end

endmodule
